// ===== src/smx4_pkg.sv =====
package smx4_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int LANES           = 4;
	localparam int LATENCY         = 6;

	localparam int MASTER_W = 15;
	localparam int VOL_W    = 16;
	localparam int PAN_W    = 16;
	localparam int FACT_W   = 16;
	localparam int MF_W     = MASTER_W + FACT_W;
	localparam int RAW_W    = MF_W + VOL_W;
	localparam int GAIN_W   = 32;
	localparam int GAIN_SHIFT = 14;
	localparam int ACC_SHIFT  = 28;
	localparam int UNITY_Q14  = 16384;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MASTER = 3'd0,
		CFG_VOLUMES = 3'd1,
		CFG_PANS = 3'd2,
		CFG_MUTE = 3'd3,
		CFG_SOLO = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [MASTER_W-1:0] master;
		logic [VOL_W-1:0]    vol;
		logic [PAN_W-1:0]    pan;
		logic                silent;
	} lane_cfg_t;

endpackage

// ===== src/stereo_mixer_four_channel_top.sv =====
// Four-channel stereo mixer with mute, solo and pan.
// Input: pulse start with four signed samples and the block end marker; a
// frame transfers at a rising edge with start high and busy low. busy stays
// low, so a frame may be given every cycle.
// Output: done is high for one cycle with mix_left, mix_right and
// block_end_out; the receiver takes the result in that cycle and cannot
// hold it off.
// Pipeline: lane registers s1 to s4, then sum s5 and output s6, with valid
// and block end bits shifted in step. Throughput is
// one frame per cycle: each channel has its own lane (master by pan factor,
// times volume, rounding, times sample), and one adder tree per side sums the
// lanes before rounding and saturation.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 master
// gain, 1 volumes, 2 pans, 3 mute mask, 4 solo mask); other indexes are
// ignored. Write only while no frame is in flight.
// Reset: arst_n clears the valid and block end bits of the pipeline and
// returns the registers to unity gains, centre pans and no mute or solo.
module stereo_mixer_four_channel_top #(
	parameter int SAMPLE_BITS = smx4_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [SAMPLE_BITS-1:0]       sample_one,
	input  logic signed [SAMPLE_BITS-1:0]       sample_two,
	input  logic signed [SAMPLE_BITS-1:0]       sample_three,
	input  logic signed [SAMPLE_BITS-1:0]       sample_four,
	input  logic                                block_end_in,
	input  logic                                cfg_we,
	input  logic [smx4_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [smx4_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                done,
	output logic signed [SAMPLE_BITS-1:0]       mix_left,
	output logic signed [SAMPLE_BITS-1:0]       mix_right,
	output logic                                block_end_out
);
	import smx4_pkg::*;

	localparam int PW = GAIN_W + SAMPLE_BITS + 1;

	logic [MASTER_W-1:0]       master_q;
	logic [CFG_DATA_W-1:0]     volumes_q;
	logic [CFG_DATA_W-1:0]     pans_q;
	logic [LANES-1:0]          mute_q;
	logic [LANES-1:0]          solo_q;
	logic [LATENCY-1:0]        valid_q;
	logic [LATENCY-1:0]        bend_q;

	logic signed [SAMPLE_BITS-1:0] samples [LANES];
	logic signed [PW-1:0]          prod_l [LANES];
	logic signed [PW-1:0]          prod_r [LANES];
	lane_cfg_t                     lane_cfg [LANES];
	logic                          accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign samples[0] = sample_one;
	assign samples[1] = sample_two;
	assign samples[2] = sample_three;
	assign samples[3] = sample_four;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_q  <= MASTER_W'(UNITY_Q14);
			volumes_q <= 64'h4000_4000_4000_4000;
			pans_q    <= '0;
			mute_q    <= '0;
			solo_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MASTER: master_q <= cfg_data[MASTER_W-1:0];
				CFG_VOLUMES: volumes_q <= cfg_data;
				CFG_PANS: pans_q <= cfg_data;
				CFG_MUTE: mute_q <= cfg_data[LANES-1:0];
				CFG_SOLO: solo_q <= cfg_data[LANES-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			bend_q  <= '0;
		end else begin
			valid_q <= {valid_q[LATENCY-2:0], accept};
			bend_q  <= {bend_q[LATENCY-2:0], block_end_in};
		end
	end

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		always_comb begin
			lane_cfg[k].master = master_q;
			lane_cfg[k].vol    = volumes_q[VOL_W*k +: VOL_W];
			lane_cfg[k].pan    = pans_q[PAN_W*k +: PAN_W];
			lane_cfg[k].silent = mute_q[k] || ((solo_q != '0) && !solo_q[k]);
		end

		smx4_lane #(
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_lane (
			.clk   (clk),
			.cfg   (lane_cfg[k]),
			.sample(samples[k]),
			.prod_l(prod_l[k]),
			.prod_r(prod_r[k])
		);
	end

	smx4_merge #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_merge_l (
		.clk (clk),
		.prod(prod_l),
		.mix (mix_left)
	);

	smx4_merge #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_merge_r (
		.clk (clk),
		.prod(prod_r),
		.mix (mix_right)
	);

	assign done          = valid_q[LATENCY-1];
	assign block_end_out = bend_q[LATENCY-1];

`ifndef SYNTHESIS
	a_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##6 done)
		else $error("transfer in without result six cycles later");
	a_done_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 6))
		else $error("result without matching transfer in");
	a_bend: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (block_end_out == $past(block_end_in, 6)))
		else $error("block end marker out of step with its frame");
`endif

endmodule

// ===== src/smx4_lane.sv =====
module smx4_lane #(
	parameter int SAMPLE_BITS = smx4_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                              clk,
	input  smx4_pkg::lane_cfg_t                               cfg,
	input  logic signed [SAMPLE_BITS-1:0]                     sample,
	output logic signed [smx4_pkg::GAIN_W+SAMPLE_BITS:0]      prod_l,
	output logic signed [smx4_pkg::GAIN_W+SAMPLE_BITS:0]      prod_r
);
	import smx4_pkg::*;

	localparam int PW = GAIN_W + SAMPLE_BITS + 1;
	localparam logic signed [PAN_W-1:0] PAN_MAX = PAN_W'(UNITY_Q14);
	localparam logic signed [PAN_W-1:0] PAN_MIN = -PAN_W'(UNITY_Q14);
	localparam logic signed [PAN_W:0]   UNITY_X = (PAN_W+1)'(UNITY_Q14);
	localparam logic [RAW_W-1:0]        GAIN_HALF = RAW_W'(1) << (GAIN_SHIFT - 1);

	logic signed [PAN_W-1:0]   pan_c;
	logic signed [PAN_W:0]     fl_w;
	logic signed [PAN_W:0]     fr_w;

	logic [MF_W-1:0]               mfl_s1, mfr_s1;
	logic [VOL_W-1:0]              vol_s1;
	logic signed [SAMPLE_BITS-1:0] smp_s1, smp_s2, smp_s3;
	logic [RAW_W-1:0]              rawl_s2, rawr_s2;
	logic [GAIN_W-1:0]             gl_s3, gr_s3;
	logic signed [PW-1:0]          pl_s4, pr_s4;

	always_comb begin
		pan_c = $signed(cfg.pan);
		if (pan_c > PAN_MAX) begin
			pan_c = PAN_MAX;
		end else if (pan_c < PAN_MIN) begin
			pan_c = PAN_MIN;
		end
		fl_w = UNITY_X - (PAN_W+1)'(pan_c);
		fr_w = UNITY_X + (PAN_W+1)'(pan_c);
	end

	always_ff @(posedge clk) begin
		mfl_s1 <= MF_W'(cfg.master) * MF_W'(fl_w[FACT_W-1:0]);
		mfr_s1 <= MF_W'(cfg.master) * MF_W'(fr_w[FACT_W-1:0]);
		vol_s1 <= cfg.vol;
		smp_s1 <= cfg.silent ? '0 : sample;

		rawl_s2 <= RAW_W'(mfl_s1) * RAW_W'(vol_s1);
		rawr_s2 <= RAW_W'(mfr_s1) * RAW_W'(vol_s1);
		smp_s2  <= smp_s1;

		gl_s3  <= GAIN_W'((rawl_s2 + GAIN_HALF) >> GAIN_SHIFT);
		gr_s3  <= GAIN_W'((rawr_s2 + GAIN_HALF) >> GAIN_SHIFT);
		smp_s3 <= smp_s2;

		pl_s4 <= PW'($signed({1'b0, gl_s3})) * PW'(smp_s3);
		pr_s4 <= PW'($signed({1'b0, gr_s3})) * PW'(smp_s3);
	end

	assign prod_l = pl_s4;
	assign prod_r = pr_s4;

endmodule

// ===== src/smx4_merge.sv =====
module smx4_merge #(
	parameter int SAMPLE_BITS = smx4_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                          clk,
	input  logic signed [smx4_pkg::GAIN_W+SAMPLE_BITS:0]  prod [smx4_pkg::LANES],
	output logic signed [SAMPLE_BITS-1:0]                 mix
);
	import smx4_pkg::*;

	localparam int PW = GAIN_W + SAMPLE_BITS + 1;
	localparam int AW = PW + $clog2(LANES);
	localparam logic signed [AW-1:0] ROUND_HALF = AW'(1) <<< (ACC_SHIFT - 1);
	localparam logic signed [AW-1:0] SAT_HI = (AW'(1) <<< (SAMPLE_BITS - 1)) - AW'(1);
	localparam logic signed [AW-1:0] SAT_LO = -(AW'(1) <<< (SAMPLE_BITS - 1));

	logic signed [AW-1:0]          sum;
	logic signed [AW-1:0]          sum_s5;
	logic signed [AW-1:0]          rnd;
	logic signed [SAMPLE_BITS-1:0] mix_s6;

	always_comb begin
		sum = '0;
		for (int k = 0; k < LANES; k++) begin
			sum = sum + AW'(prod[k]);
		end
		rnd = (sum_s5 + ROUND_HALF) >>> ACC_SHIFT;
	end

	always_ff @(posedge clk) begin
		sum_s5 <= sum;
		priority if (rnd > SAT_HI) begin
			mix_s6 <= SAT_HI[SAMPLE_BITS-1:0];
		end else if (rnd < SAT_LO) begin
			mix_s6 <= SAT_LO[SAMPLE_BITS-1:0];
		end else begin
			mix_s6 <= rnd[SAMPLE_BITS-1:0];
		end
	end

	assign mix = mix_s6;

endmodule

// ===== dv/stereo_mix_checker.sv =====
`timescale 1ns / 100ps

module stereo_mix_checker #(
	parameter int SB = smx4_pkg::SAMPLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  logic signed [SB-1:0]            sample_one,
	input  logic signed [SB-1:0]            sample_two,
	input  logic signed [SB-1:0]            sample_three,
	input  logic signed [SB-1:0]            sample_four,
	input  logic                            block_end_in,
	input  logic                            cfg_we,
	input  logic [smx4_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [smx4_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            done,
	input  logic signed [SB-1:0]            mix_left,
	input  logic signed [SB-1:0]            mix_right,
	input  logic                            block_end_out,
	output int                              errors,
	output int                              pending,
	output int                              results
);
	import smx4_pkg::*;

	typedef struct packed {
		logic signed [SB-1:0] left;
		logic signed [SB-1:0] right;
		logic                 blk;
	} mix_result_t;

	logic [MASTER_W-1:0]    master_q;
	logic [LANES*VOL_W-1:0] vols_q;
	logic [LANES*PAN_W-1:0] pans_q;
	logic [LANES-1:0]       mute_q;
	logic [LANES-1:0]       solo_q;

	mix_result_t expected_mix[$];
	mix_result_t want;

	function automatic longint lane_gain(input longint factor, input longint vol);
		longint raw;
		raw = longint'(master_q) * factor * vol;
		return (raw + (longint'(1) <<< (GAIN_SHIFT - 1))) >>> GAIN_SHIFT;
	endfunction

	function automatic logic signed [SB-1:0] round_saturate(input longint acc);
		longint r;
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (SB - 1)) - 1;
		lo = -hi - 1;
		r = (acc + (longint'(1) <<< (ACC_SHIFT - 1))) >>> ACC_SHIFT;
		if (r > hi)
			r = hi;
		if (r < lo)
			r = lo;
		return r[SB-1:0];
	endfunction

	function automatic mix_result_t mix_frame(input logic [LANES*SB-1:0] smps, input logic blk);
		mix_result_t r;
		longint acc_l;
		longint acc_r;
		longint s;
		longint vol;
		longint pan;
		logic signed [SB-1:0] smp;
		logic signed [PAN_W-1:0] pan_raw;
		logic any_solo;
		logic silent;
		acc_l = 0;
		acc_r = 0;
		any_solo = |solo_q;
		for (int k = 0; k < LANES; k++) begin
			smp = smps[k*SB +: SB];
			s = smp;
			silent = mute_q[k] || (any_solo && !solo_q[k]);
			if (!silent) begin
				vol = longint'(vols_q[k*VOL_W +: VOL_W]);
				pan_raw = pans_q[k*PAN_W +: PAN_W];
				pan = pan_raw;
				if (pan > UNITY_Q14)
					pan = UNITY_Q14;
				if (pan < -UNITY_Q14)
					pan = -UNITY_Q14;
				acc_l += lane_gain(UNITY_Q14 - pan, vol) * s;
				acc_r += lane_gain(UNITY_Q14 + pan, vol) * s;
			end
		end
		r.left = round_saturate(acc_l);
		r.right = round_saturate(acc_r);
		r.blk = blk;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_q = MASTER_W'(UNITY_Q14);
			vols_q = {LANES{VOL_W'(UNITY_Q14)}};
			pans_q = '0;
			mute_q = '0;
			solo_q = '0;
			expected_mix.delete();
		end else begin
			if (done) begin
				if (expected_mix.size() == 0) begin
					errors++;
					$display("%0t: unexpected transfer, expected none, got left %0d right %0d end %0b",
						$time, mix_left, mix_right, block_end_out);
				end else begin
					want = expected_mix.pop_front();
					results++;
					if (mix_left !== want.left) begin
						errors++;
						$display("%0t: mix_left expected %0d, got %0d", $time, want.left, mix_left);
					end
					if (mix_right !== want.right) begin
						errors++;
						$display("%0t: mix_right expected %0d, got %0d", $time, want.right, mix_right);
					end
					if (block_end_out !== want.blk) begin
						errors++;
						$display("%0t: block_end_out expected %0b, got %0b",
							$time, want.blk, block_end_out);
					end
				end
			end
			if (start && !busy)
				expected_mix.push_back(mix_frame({sample_four, sample_three, sample_two,
					sample_one}, block_end_in));
			if (cfg_we) begin
				case (cfg_index)
					CFG_MASTER: master_q = cfg_data[MASTER_W-1:0];
					CFG_VOLUMES: vols_q = cfg_data[LANES*VOL_W-1:0];
					CFG_PANS: pans_q = cfg_data[LANES*PAN_W-1:0];
					CFG_MUTE: mute_q = cfg_data[LANES-1:0];
					CFG_SOLO: solo_q = cfg_data[LANES-1:0];
					default: ;
				endcase
			end
		end
		pending = expected_mix.size();
	end

endmodule

// ===== dv/stereo_mixer_four_channel_top_tb.sv =====
`timescale 1ns / 100ps

module stereo_mixer_four_channel_top_tb;
	import smx4_pkg::*;

	localparam int SB          = SAMPLE_BITS_DEF;
	localparam int CLK_PERIOD  = 10;
	localparam int STALL_LIMIT = 2000;
	localparam int RAND_PHASES = 10;
	localparam int PHASE_ITEMS = 60;

	localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
	localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};
	localparam logic [VOL_W-1:0] VOL_UNITY = VOL_W'(UNITY_Q14);
	localparam logic [PAN_W-1:0] PAN_LEFT  = 16'hC000;
	localparam logic [PAN_W-1:0] PAN_RIGHT = 16'h4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic block_end_in = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic signed [SB-1:0] sample_one = '0;
	logic signed [SB-1:0] sample_two = '0;
	logic signed [SB-1:0] sample_three = '0;
	logic signed [SB-1:0] sample_four = '0;

	wire busy;
	wire done;
	wire block_end_out;
	wire signed [SB-1:0] mix_left;
	wire signed [SB-1:0] mix_right;

	int mismatches;
	int pending;
	int results;
	int frames_sent = 0;
	int settings_used = 0;
	int stall_cycles = 0;
	bit gaps_on = 1'b1;

	always #(CLK_PERIOD / 2) clk = ~clk;

	stereo_mixer_four_channel_top #(.SAMPLE_BITS(SB)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.sample_one(sample_one),
		.sample_two(sample_two),
		.sample_three(sample_three),
		.sample_four(sample_four),
		.block_end_in(block_end_in),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.mix_left(mix_left),
		.mix_right(mix_right),
		.block_end_out(block_end_out)
	);

	stereo_mix_checker #(.SB(SB)) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.sample_one(sample_one),
		.sample_two(sample_two),
		.sample_three(sample_three),
		.sample_four(sample_four),
		.block_end_in(block_end_in),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.mix_left(mix_left),
		.mix_right(mix_right),
		.block_end_out(block_end_out),
		.errors(mismatches),
		.pending(pending),
		.results(results)
	);

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("stereo_mixer_four_channel_top_tb: done, errors");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic logic signed [SB-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return S_MAX;
			1: return S_MIN;
			2, 3: return SB'($signed($urandom_range(0, 512)) - 256);
			default: return SB'($urandom);
		endcase
	endfunction

	function automatic logic [VOL_W-1:0] rand_volume();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return VOL_UNITY;
			4, 5, 6: return VOL_W'($urandom_range(0, UNITY_Q14));
			default: return VOL_W'($urandom);
		endcase
	endfunction

	function automatic logic [PAN_W-1:0] rand_pan();
		case ($urandom_range(0, 9))
			0: return PAN_LEFT;
			1: return PAN_RIGHT;
			2: return '0;
			3, 4: return PAN_W'($urandom);
			default: return PAN_W'($signed($urandom_range(0, 2 * UNITY_Q14)) - UNITY_Q14);
		endcase
	endfunction

	function automatic int gap_len();
		if (!gaps_on)
			return 0;
		case ($urandom_range(0, 19))
			0: return $urandom_range(10, 40);
			1, 2, 3, 4, 5, 6, 7: return $urandom_range(1, 3);
			default: return 0;
		endcase
	endfunction

	task automatic gap(input int n);
		if (n > 0) begin
			@(negedge clk);
			start <= 1'b0;
			sample_one <= rand_sample();
			sample_two <= rand_sample();
			sample_three <= rand_sample();
			sample_four <= rand_sample();
			block_end_in <= $urandom_range(0, 1);
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic send_frame(input logic signed [SB-1:0] a, input logic signed [SB-1:0] b,
		input logic signed [SB-1:0] c, input logic signed [SB-1:0] d, input logic blk);
		@(negedge clk);
		start <= 1'b1;
		sample_one <= a;
		sample_two <= b;
		sample_three <= c;
		sample_four <= d;
		block_end_in <= blk;
		@(posedge clk);
		while (busy) @(posedge clk);
		frames_sent++;
		gap(gap_len());
	endtask

	task automatic send_random();
		send_frame(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
			$urandom_range(0, 1));
	endtask

	// drop start and let the pipeline drain
	task automatic quiesce();
		@(negedge clk);
		start <= 1'b0;
		wait (pending == 0);
		repeat (LATENCY + 2) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic configure(input logic [MASTER_W-1:0] m, input logic [63:0] vols,
		input logic [63:0] pans, input logic [LANES-1:0] mute, input logic [LANES-1:0] solo);
		logic [CFG_DATA_W-1:0] junk;
		quiesce();
		junk = {$urandom, $urandom};
		junk[MASTER_W-1:0] = m;
		write_reg(CFG_MASTER, junk);
		write_reg(CFG_VOLUMES, vols);
		write_reg(CFG_PANS, pans);
		junk = {$urandom, $urandom};
		junk[LANES-1:0] = mute;
		write_reg(CFG_MUTE, junk);
		junk = {$urandom, $urandom};
		junk[LANES-1:0] = solo;
		write_reg(CFG_SOLO, junk);
		write_reg(CFG_SOLO + CFG_IDX_W'($urandom_range(1, 3)), {$urandom, $urandom});
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic configure_random();
		logic [MASTER_W-1:0] m;
		logic [63:0] vols;
		logic [63:0] pans;
		case ($urandom_range(0, 7))
			0: m = '0;
			1: m = '1;
			2, 3: m = MASTER_W'(UNITY_Q14);
			default: m = MASTER_W'($urandom);
		endcase
		for (int k = 0; k < LANES; k++) begin
			vols[k*VOL_W +: VOL_W] = rand_volume();
			pans[k*PAN_W +: PAN_W] = rand_pan();
		end
		configure(m, vols, pans,
			($urandom_range(0, 2) == 0) ? LANES'($urandom) : '0,
			($urandom_range(0, 2) == 0) ? LANES'($urandom) : '0);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset setting: unity gains, centre pans
		send_frame('0, '0, '0, '0, 1'b0);
		send_frame(S_MAX, S_MAX, S_MAX, S_MAX, 1'b1);
		send_frame(S_MIN, S_MIN, S_MIN, S_MIN, 1'b0);
		send_frame(S_MAX, S_MIN, S_MAX, S_MIN, 1'b1);
		send_frame(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 1'b0);
		send_frame(1, -1, 1, -1, 1'b1);

		// full gains, pans at and beyond both ends
		configure('1, '1, {PAN_RIGHT, PAN_LEFT, 16'h7FFF, 16'h8000}, '0, '0);
		send_frame(S_MAX, S_MAX, S_MAX, S_MAX, 1'b0);
		send_frame(S_MIN, S_MIN, S_MIN, S_MIN, 1'b1);
		send_frame(1, -1, 0, 0, 1'b0);
		send_frame('0, '0, '0, '0, 1'b1);

		configure('0, {16'hFFFF, 16'h0000, VOL_UNITY, 16'h0000}, '0, '0, '0);
		send_frame(S_MAX, S_MIN, S_MAX, S_MIN, 1'b1);

		// tiny gains exercise the rounding
		configure(MASTER_W'(1), {16'h0003, 16'h0001, 16'h0007, 16'h00FF},
			{16'h2000, 16'hE000, 16'h0001, 16'h0000}, '0, '0);
		send_frame(S_MAX, S_MIN, 16'sh1234, -16'sh4321, 1'b0);
		send_frame(S_MIN, S_MAX, -16'sh0777, 16'sh0777, 1'b1);

		configure(MASTER_W'(UNITY_Q14), {LANES{VOL_UNITY}},
			{16'h1000, 16'h0000, 16'h2000, 16'hE000}, 4'b0101, '0);
		send_frame(16'sh1000, 16'sh2000, 16'sh0400, 16'sh0800, 1'b0);
		send_frame(S_MAX, S_MAX, S_MAX, S_MAX, 1'b1);

		configure(MASTER_W'(UNITY_Q14), {LANES{VOL_UNITY}},
			{16'h1000, 16'h0000, 16'h2000, 16'hE000}, 4'b0001, 4'b0011);
		send_frame(16'sh1000, 16'sh2000, 16'sh0400, 16'sh0800, 1'b0);
		send_frame(S_MIN, S_MIN, S_MIN, S_MIN, 1'b1);

		configure(MASTER_W'(UNITY_Q14), {LANES{VOL_UNITY}},
			{16'h1000, 16'h0000, 16'h2000, 16'hE000}, '0, 4'b1000);
		send_frame(16'sh1000, 16'sh2000, 16'sh0400, 16'sh0800, 1'b0);
		send_frame(S_MAX, S_MIN, S_MAX, S_MIN, 1'b1);

		for (int p = 0; p < RAND_PHASES; p++) begin
			configure_random();
			gaps_on = (p % 3) != 0;
			repeat (PHASE_ITEMS) send_random();
		end

		quiesce();
		$display("%0d frames over %0d register settings, %0d stereo results checked",
			frames_sent, settings_used, results);
		if (mismatches == 0 && pending == 0)
			$display("stereo_mixer_four_channel_top_tb: done, clean");
		else
			$display("stereo_mixer_four_channel_top_tb: done, errors");
		$finish;
	end

endmodule
